// ----- src/rdp_pkg.sv -----
// ----------------------------------------------------------------------------
// rdp_pkg
// Shared constants, types and command codes of the polyline simplifier.
// ----------------------------------------------------------------------------
`default_nettype none

package rdp_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int QDEPTH = MAX_POINTS - 1;
  localparam int QA_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QC_W   = $clog2(QDEPTH + 1);
  localparam int ERR_W  = 2 * COORD_BITS + 2;
  localparam int NL_W   = 7;
  localparam int CFG_W  = ERR_W;
  localparam int DC_W   = $clog2(COORD_BITS);

  localparam logic CFG_ERR_LIMIT  = 1'b0;
  localparam logic CFG_NODE_LIMIT = 1'b1;
  localparam logic [NL_W-1:0] NODE_LIMIT_RESET = 7'd64;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] split;
    logic [ERR_W-1:0] err;
  } qent_t;

  localparam logic [4:0] OP_IDLE     = 5'd0;
  localparam logic [4:0] OP_LOAD     = 5'd1;
  localparam logic [4:0] OP_START    = 5'd2;
  localparam logic [4:0] OP_SPAN1    = 5'd3;
  localparam logic [4:0] OP_SPAN2    = 5'd4;
  localparam logic [4:0] OP_RD_A     = 5'd5;
  localparam logic [4:0] OP_RD_B     = 5'd6;
  localparam logic [4:0] OP_LAT_B    = 5'd7;
  localparam logic [4:0] OP_DIV_INIT = 5'd8;
  localparam logic [4:0] OP_DIV_STEP = 5'd9;
  localparam logic [4:0] OP_SC_INIT  = 5'd10;
  localparam logic [4:0] OP_SC_RD    = 5'd11;
  localparam logic [4:0] OP_SC_SQ    = 5'd12;
  localparam logic [4:0] OP_SC_CMP   = 5'd13;
  localparam logic [4:0] OP_SC_WR    = 5'd14;
  localparam logic [4:0] OP_TOP_INIT = 5'd15;
  localparam logic [4:0] OP_T_RD     = 5'd16;
  localparam logic [4:0] OP_T_CMP    = 5'd17;
  localparam logic [4:0] OP_P_RL     = 5'd18;
  localparam logic [4:0] OP_P_WR     = 5'd19;
  localparam logic [4:0] OP_E_INIT   = 5'd20;
  localparam logic [4:0] OP_E_CHK    = 5'd21;
  localparam logic [4:0] OP_E_OUT    = 5'd22;
  localparam logic [4:0] OP_CLEAR    = 5'd23;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] coord;
  } cmd_t;

  typedef struct packed {
    logic accept_last;
    logic multi;
    logic div_last;
    logic has_int;
    logic sc_more;
    logic q_empty;
    logic t_more;
    logic t_go;
    logic push1;
    logic push2;
    logic e_done;
    logic e_mark;
    logic out_free;
  } stat_t;

  function automatic logic signed [COORD_BITS-1:0] pt_coord(point_t p, logic [1:0] c);
    case (c)
      2'd0:    pt_coord = p.x;
      2'd1:    pt_coord = p.y;
      default: pt_coord = p.z;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- src/rdp_if.sv -----
// ----------------------------------------------------------------------------
// rdp_if
// Point input and kept-point output channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rdp_pkg::COORD_BITS-1:0] px;
  logic signed [rdp_pkg::COORD_BITS-1:0] py;
  logic signed [rdp_pkg::COORD_BITS-1:0] pz;
  logic                                  is_last;
  modport source (output valid, px, py, pz, is_last, input ready);
  modport sink   (input valid, px, py, pz, is_last, output ready);
endinterface

interface rdp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rdp_pkg::COORD_BITS-1:0] qx;
  logic signed [rdp_pkg::COORD_BITS-1:0] qy;
  logic signed [rdp_pkg::COORD_BITS-1:0] qz;
  logic [rdp_pkg::IDX_W-1:0]             orig_index;
  logic                                  end_of_run;
  logic [rdp_pkg::ERR_W-1:0]             worst_left_sq;
  logic                                  overflowed;
  modport source (output valid, qx, qy, qz, orig_index, end_of_run, worst_left_sq,
                  overflowed, input ready);
  modport sink   (input valid, qx, qy, qz, orig_index, end_of_run, worst_left_sq,
                  overflowed, output ready);
endinterface

`default_nettype wire

// ----- src/rdp_ctrl.sv -----
// ----------------------------------------------------------------------------
// rdp_ctrl
// Sequencer for load, span scoring, queue refinement and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module rdp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rdp_pkg::stat_t st,
  output rdp_pkg::cmd_t      cmd
);

  localparam logic [4:0] S_LOAD     = 5'd0;
  localparam logic [4:0] S_START    = 5'd1;
  localparam logic [4:0] S_RD_A     = 5'd2;
  localparam logic [4:0] S_RD_B     = 5'd3;
  localparam logic [4:0] S_LAT_B    = 5'd4;
  localparam logic [4:0] S_DIV_INIT = 5'd5;
  localparam logic [4:0] S_DIV_STEP = 5'd6;
  localparam logic [4:0] S_SC_INIT  = 5'd7;
  localparam logic [4:0] S_SC_RD    = 5'd8;
  localparam logic [4:0] S_SC_SQ    = 5'd9;
  localparam logic [4:0] S_SC_CMP   = 5'd10;
  localparam logic [4:0] S_SC_WR    = 5'd11;
  localparam logic [4:0] S_PUSH1    = 5'd12;
  localparam logic [4:0] S_PUSH2    = 5'd13;
  localparam logic [4:0] S_TOP_INIT = 5'd14;
  localparam logic [4:0] S_T_RD     = 5'd15;
  localparam logic [4:0] S_T_CMP    = 5'd16;
  localparam logic [4:0] S_T_DEC    = 5'd17;
  localparam logic [4:0] S_P_RL     = 5'd18;
  localparam logic [4:0] S_P_WR     = 5'd19;
  localparam logic [4:0] S_E_INIT   = 5'd20;
  localparam logic [4:0] S_E_CHK    = 5'd21;
  localparam logic [4:0] S_E_OUT    = 5'd22;
  localparam logic [4:0] S_CLEAR    = 5'd23;

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_LEFT  = 2'd1;
  localparam logic [1:0] PH_RIGHT = 2'd2;

  logic [4:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic [1:0] coord, coord_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      phase <= PH_FIRST;
      coord <= 2'd0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      coord <= coord_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    coord_next = coord;
    cmd.op     = rdp_pkg::OP_IDLE;
    cmd.coord  = coord;
    case (state)
      S_LOAD: begin
        cmd.op = rdp_pkg::OP_LOAD;
        if (st.accept_last) state_next = S_START;
      end
      S_START: begin
        cmd.op     = rdp_pkg::OP_START;
        phase_next = PH_FIRST;
        state_next = st.multi ? S_RD_A : S_E_INIT;
      end
      S_RD_A: begin
        cmd.op     = rdp_pkg::OP_RD_A;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        cmd.op     = rdp_pkg::OP_RD_B;
        state_next = S_LAT_B;
      end
      S_LAT_B: begin
        cmd.op     = rdp_pkg::OP_LAT_B;
        coord_next = 2'd0;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op     = rdp_pkg::OP_DIV_INIT;
        state_next = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.op = rdp_pkg::OP_DIV_STEP;
        if (st.div_last) begin
          if (coord == 2'd2) begin
            state_next = S_SC_INIT;
          end else begin
            coord_next = coord + 2'd1;
            state_next = S_DIV_INIT;
          end
        end
      end
      S_SC_INIT: begin
        cmd.op     = rdp_pkg::OP_SC_INIT;
        state_next = st.has_int ? S_SC_RD : S_SC_WR;
      end
      S_SC_RD: begin
        cmd.op     = rdp_pkg::OP_SC_RD;
        coord_next = 2'd0;
        state_next = S_SC_SQ;
      end
      S_SC_SQ: begin
        cmd.op = rdp_pkg::OP_SC_SQ;
        if (coord == 2'd2) begin
          state_next = S_SC_CMP;
        end else begin
          coord_next = coord + 2'd1;
        end
      end
      S_SC_CMP: begin
        cmd.op     = rdp_pkg::OP_SC_CMP;
        state_next = st.sc_more ? S_SC_RD : S_SC_WR;
      end
      S_SC_WR: begin
        cmd.op     = rdp_pkg::OP_SC_WR;
        state_next = (phase == PH_LEFT) ? S_PUSH2 : S_TOP_INIT;
      end
      S_TOP_INIT: begin
        cmd.op     = rdp_pkg::OP_TOP_INIT;
        state_next = st.q_empty ? S_T_DEC : S_T_RD;
      end
      S_T_RD: begin
        cmd.op     = rdp_pkg::OP_T_RD;
        state_next = S_T_CMP;
      end
      S_T_CMP: begin
        cmd.op     = rdp_pkg::OP_T_CMP;
        state_next = st.t_more ? S_T_RD : S_T_DEC;
      end
      S_T_DEC: begin
        state_next = st.t_go ? S_P_RL : S_E_INIT;
      end
      S_P_RL: begin
        cmd.op     = rdp_pkg::OP_P_RL;
        state_next = S_P_WR;
      end
      S_P_WR: begin
        cmd.op     = rdp_pkg::OP_P_WR;
        state_next = S_PUSH1;
      end
      S_PUSH1: begin
        if (st.push1) begin
          cmd.op     = rdp_pkg::OP_SPAN1;
          phase_next = PH_LEFT;
          state_next = S_RD_A;
        end else begin
          state_next = S_PUSH2;
        end
      end
      S_PUSH2: begin
        if (st.push2) begin
          cmd.op     = rdp_pkg::OP_SPAN2;
          phase_next = PH_RIGHT;
          state_next = S_RD_A;
        end else begin
          state_next = S_TOP_INIT;
        end
      end
      S_E_INIT: begin
        cmd.op     = rdp_pkg::OP_E_INIT;
        state_next = S_E_CHK;
      end
      S_E_CHK: begin
        cmd.op = rdp_pkg::OP_E_CHK;
        if (st.e_done) state_next = S_CLEAR;
        else if (st.e_mark) state_next = S_E_OUT;
      end
      S_E_OUT: begin
        cmd.op = rdp_pkg::OP_E_OUT;
        if (st.out_free) state_next = S_E_CHK;
      end
      S_CLEAR: begin
        cmd.op     = rdp_pkg::OP_CLEAR;
        state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/rdp_dp.sv -----
// ----------------------------------------------------------------------------
// rdp_dp
// Datapath: point and span memories, span scorer with shared divider,
// queue search, kept marks and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rdp_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  rdp_in_if.sink                          in_ch,
  rdp_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [rdp_pkg::CFG_W-1:0]  cfg_data,
  input  wire rdp_pkg::cmd_t              cmd,
  output rdp_pkg::stat_t                  st
);

  localparam int CW  = rdp_pkg::COORD_BITS;
  localparam int IW  = rdp_pkg::IDX_W;
  localparam int NW  = rdp_pkg::CNT_W;
  localparam int EW  = rdp_pkg::ERR_W;
  localparam int AW  = rdp_pkg::QA_W;
  localparam int CCW = rdp_pkg::QC_W;

  rdp_pkg::point_t pmem [rdp_pkg::MAX_POINTS];
  rdp_pkg::point_t prd;
  rdp_pkg::qent_t  qmem [rdp_pkg::QDEPTH];
  rdp_pkg::qent_t  qrd;

  logic [EW-1:0]             err_limit;
  logic [rdp_pkg::NL_W-1:0]  node_limit;

  logic [NW-1:0]  load_count;
  logic           ovf;
  logic [CCW-1:0] span_count;
  logic [rdp_pkg::MAX_POINTS-1:0] marks;
  logic [NW-1:0]  kept_count;

  logic [IW-1:0]   sa, sb;
  rdp_pkg::point_t pa, pb;

  logic [CW-1:0]   dsh;
  logic [IW-1:0]   drem;
  logic [rdp_pkg::DC_W-1:0] dcnt;
  logic [CW-1:0]   qd [3];
  logic [IW-1:0]   rd [3];
  logic            neg [3];
  logic [CW-1:0]   qv [3];
  logic [IW-1:0]   rv [3];

  logic [IW-1:0]   si;
  logic [2*CW-1:0] sq;
  logic [EW-1:0]   acc;
  logic [EW-1:0]   s_err;
  logic [IW-1:0]   s_split;

  logic [AW-1:0]   k, bk;
  logic [IW-1:0]   ba, bb, bs;
  logic [EW-1:0]   berr;

  logic [NW-1:0]   e;
  logic [NW-1:0]   emitted;
  logic            ovld;

  logic accept, pwe, prd_en, qwe, qre;
  logic [IW-1:0] prd_addr;
  logic [AW-1:0] qwaddr, qraddr;
  rdp_pkg::qent_t qwdata;

  logic signed [CW-1:0] ca, cb, ci;
  logic signed [CW:0]   dd;
  logic [CW-1:0]        absd;
  logic [IW-1:0]        den;
  logic [IW:0]          trial;
  logic                 qbit;
  logic [IW-1:0]        drem_n;
  logic signed [CW+1:0] qext, ipx, xv;
  logic signed [2*CW+3:0] xx;
  logic [EW-1:0]        esum;
  logic                 better;
  logic                 out_free;

  assign accept       = (cmd.op == rdp_pkg::OP_LOAD) && in_ch.valid;
  assign in_ch.ready  = (cmd.op == rdp_pkg::OP_LOAD);
  assign pwe          = accept && (load_count < NW'(rdp_pkg::MAX_POINTS));
  assign out_free     = !ovld || out_ch.ready;
  assign out_ch.valid = ovld;

  assign ca   = rdp_pkg::pt_coord(pa, cmd.coord);
  assign cb   = rdp_pkg::pt_coord(pb, cmd.coord);
  assign ci   = rdp_pkg::pt_coord(prd, cmd.coord);
  assign dd   = $signed({cb[CW-1], cb}) - $signed({ca[CW-1], ca});
  assign absd = dd[CW] ? CW'(-dd) : dd[CW-1:0];
  assign den  = sb - sa;

  assign trial  = {drem, dsh[CW-1]};
  assign qbit   = (trial >= {1'b0, den});
  assign drem_n = qbit ? IW'(trial - {1'b0, den}) : trial[IW-1:0];

  assign qext = $signed({2'b00, qv[cmd.coord]});
  assign ipx  = $signed({{2{ca[CW-1]}}, ca}) + (neg[cmd.coord] ? -qext : qext);
  assign xv   = ipx - $signed({{2{ci[CW-1]}}, ci});
  assign xx   = xv * xv;
  assign esum = acc + EW'(sq);

  assign better = (k == '0) || (qrd.err > berr) || ((qrd.err == berr) && (qrd.a < ba));

  assign st.accept_last = accept && in_ch.is_last;
  assign st.multi       = load_count > NW'(1);
  assign st.div_last    = dcnt == rdp_pkg::DC_W'(CW - 1);
  assign st.has_int     = ({1'b0, sa} + (IW+1)'(1)) < {1'b0, sb};
  assign st.sc_more     = ({1'b0, si} + (IW+1)'(1)) < {1'b0, sb};
  assign st.q_empty     = span_count == '0;
  assign st.t_more      = (CCW'(k) + CCW'(1)) < span_count;
  assign st.t_go        = (berr > err_limit) && (kept_count < node_limit);
  assign st.push1       = (bs - ba) > IW'(1);
  assign st.push2       = (bb - bs) > IW'(1);
  assign st.e_done      = e == load_count;
  assign st.e_mark      = marks[e[IW-1:0]];
  assign st.out_free    = out_free;

  always_comb begin
    prd_en   = 1'b0;
    prd_addr = sa;
    qre      = 1'b0;
    qraddr   = k;
    qwe      = 1'b0;
    qwaddr   = span_count[AW-1:0];
    qwdata   = '{a: sa, b: sb, split: s_split, err: s_err};
    case (cmd.op)
      rdp_pkg::OP_RD_A: prd_en = 1'b1;
      rdp_pkg::OP_RD_B: begin
        prd_en   = 1'b1;
        prd_addr = sb;
      end
      rdp_pkg::OP_SC_RD: begin
        prd_en   = 1'b1;
        prd_addr = si;
      end
      rdp_pkg::OP_E_CHK: begin
        prd_en   = !st.e_done && st.e_mark;
        prd_addr = e[IW-1:0];
      end
      rdp_pkg::OP_SC_WR: qwe = span_count < CCW'(rdp_pkg::QDEPTH);
      rdp_pkg::OP_T_RD:  qre = 1'b1;
      rdp_pkg::OP_P_RL: begin
        qre    = 1'b1;
        qraddr = AW'(span_count - CCW'(1));
      end
      rdp_pkg::OP_P_WR: begin
        qwe    = 1'b1;
        qwaddr = bk;
        qwdata = qrd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pwe) pmem[load_count[IW-1:0]] <= '{x: in_ch.px, y: in_ch.py, z: in_ch.pz};
    if (prd_en) prd <= pmem[prd_addr];
    if (qwe) qmem[qwaddr] <= qwdata;
    if (qre) qrd <= qmem[qraddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_limit  <= '0;
      node_limit <= rdp_pkg::NODE_LIMIT_RESET;
      load_count <= '0;
      ovf        <= 1'b0;
      span_count <= '0;
      marks      <= '0;
      kept_count <= '0;
      ovld       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rdp_pkg::CFG_ERR_LIMIT:  err_limit  <= cfg_data[EW-1:0];
          rdp_pkg::CFG_NODE_LIMIT: node_limit <= cfg_data[rdp_pkg::NL_W-1:0];
          default: ;
        endcase
      end
      if ((cmd.op == rdp_pkg::OP_E_OUT) && out_free) ovld <= 1'b1;
      else if (out_ch.ready) ovld <= 1'b0;
      case (cmd.op)
        rdp_pkg::OP_LOAD: begin
          if (pwe) load_count <= load_count + NW'(1);
          else if (accept) ovf <= 1'b1;
        end
        rdp_pkg::OP_START: begin
          marks[0]   <= 1'b1;
          kept_count <= st.multi ? NW'(2) : NW'(1);
          if (st.multi) marks[IW'(load_count - NW'(1))] <= 1'b1;
        end
        rdp_pkg::OP_SC_WR: if (qwe) span_count <= span_count + CCW'(1);
        rdp_pkg::OP_P_WR: begin
          span_count <= span_count - CCW'(1);
          marks[bs]  <= 1'b1;
          kept_count <= kept_count + NW'(1);
        end
        rdp_pkg::OP_CLEAR: begin
          load_count <= '0;
          ovf        <= 1'b0;
          span_count <= '0;
          marks      <= '0;
          kept_count <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      rdp_pkg::OP_START: begin
        berr <= '0;
        sa   <= '0;
        sb   <= IW'(load_count - NW'(1));
      end
      rdp_pkg::OP_SPAN1: begin
        sa <= ba;
        sb <= bs;
      end
      rdp_pkg::OP_SPAN2: begin
        sa <= bs;
        sb <= bb;
      end
      rdp_pkg::OP_RD_B:  pa <= prd;
      rdp_pkg::OP_LAT_B: pb <= prd;
      rdp_pkg::OP_DIV_INIT: begin
        dsh              <= absd;
        drem             <= '0;
        dcnt             <= '0;
        neg[cmd.coord]   <= dd[CW];
      end
      rdp_pkg::OP_DIV_STEP: begin
        dsh  <= {dsh[CW-2:0], qbit};
        drem <= drem_n;
        dcnt <= dcnt + rdp_pkg::DC_W'(1);
        if (st.div_last) begin
          qd[cmd.coord] <= {dsh[CW-2:0], qbit};
          rd[cmd.coord] <= drem_n;
        end
      end
      rdp_pkg::OP_SC_INIT: begin
        for (int c = 0; c < 3; c++) begin
          qv[c] <= '0;
          rv[c] <= den >> 1;
        end
        si      <= sa + IW'(1);
        s_err   <= '0;
        s_split <= sa;
      end
      rdp_pkg::OP_SC_RD: begin
        for (int c = 0; c < 3; c++) begin
          if (({1'b0, rv[c]} + {1'b0, rd[c]}) >= {1'b0, den}) begin
            rv[c] <= IW'({1'b0, rv[c]} + {1'b0, rd[c]} - {1'b0, den});
            qv[c] <= qv[c] + qd[c] + CW'(1);
          end else begin
            rv[c] <= rv[c] + rd[c];
            qv[c] <= qv[c] + qd[c];
          end
        end
      end
      rdp_pkg::OP_SC_SQ: begin
        sq <= xx[2*CW-1:0];
        if (cmd.coord == 2'd1) acc <= EW'(sq);
        else if (cmd.coord == 2'd2) acc <= esum;
      end
      rdp_pkg::OP_SC_CMP: begin
        if (esum > s_err) begin
          s_err   <= esum;
          s_split <= si;
        end
        si <= si + IW'(1);
      end
      rdp_pkg::OP_TOP_INIT: begin
        k    <= '0;
        berr <= '0;
      end
      rdp_pkg::OP_T_CMP: begin
        if (better) begin
          bk   <= k;
          ba   <= qrd.a;
          bb   <= qrd.b;
          bs   <= qrd.split;
          berr <= qrd.err;
        end
        k <= k + AW'(1);
      end
      rdp_pkg::OP_E_INIT: begin
        e       <= '0;
        emitted <= '0;
      end
      rdp_pkg::OP_E_CHK: if (!st.e_done && !st.e_mark) e <= e + NW'(1);
      rdp_pkg::OP_E_OUT: begin
        if (out_free) begin
          out_ch.qx            <= prd.x;
          out_ch.qy            <= prd.y;
          out_ch.qz            <= prd.z;
          out_ch.orig_index    <= e[IW-1:0];
          out_ch.end_of_run    <= emitted == (kept_count - NW'(1));
          out_ch.worst_left_sq <= berr;
          out_ch.overflowed    <= ovf;
          e       <= e + NW'(1);
          emitted <= emitted + NW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/polyline_simplify_rdp_top.sv -----
// ----------------------------------------------------------------------------
// polyline_simplify_rdp_top
// Greedy Ramer-Douglas-Peucker simplification of one 3D polyline at a time.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    px py pz is_last
//   out_ch    out  valid/ready    qx qy qz orig_index end_of_run worst_left_sq
//                                 overflowed
//   cfg       in   cfg_we         cfg_index cfg_data (0 err_limit_sq, 1 node_limit)
//
// Points load one per cycle. After the last point, each span is scored via the
// point memory port and the shared divider, each queue pop searches all queued
// spans, and the emit scan visits every loaded point and outputs the kept ones.
// Synchronous active-high reset; no clearing pass. A stalled output holds the
// emit scan; input is taken only while loading.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_simplify_rdp_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  rdp_in_if.sink                         in_ch,
  rdp_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [rdp_pkg::CFG_W-1:0] cfg_data
);

  rdp_pkg::cmd_t  cmd;
  rdp_pkg::stat_t st;

  rdp_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  rdp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

`default_nettype wire
